// ===== sv/rob_pkg.sv =====
// ----------------------------------------------------------------------------
// rob_pkg
// Types, codes and helpers shared by the blitter front end, back end and top.
// ----------------------------------------------------------------------------
package rob_pkg;

    localparam int ADDR_BITS = 24;
    localparam int HT_WORDS  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_SLOT  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_SRC   = 2'd1;
    localparam logic [1:0] REQ_DST   = 2'd2;
    localparam logic [1:0] REQ_WRITE = 2'd3;

    localparam logic [7:0] OFF_LIMIT  = 8'h40;
    localparam logic [7:0] OFF_BYTEOK = 8'h3A;

    typedef enum logic [2:0] {
        CL_NONE,
        CL_WRITE,
        CL_READ,
        CL_SLOT,
        CL_ERR
    } t_class;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RUN,
        PH_PRE,
        PH_WPRE,
        PH_WSRC,
        PH_WDST
    } t_phase;

    typedef struct packed {
        t_class      cls;
        logic [7:0]  off;
        logic [7:0]  wbyte;
        logic        word;
        logic [15:0] mem;
    } t_item;

    typedef struct packed {
        logic [7:0]           read_byte;
        logic                 bus_error;
        logic [1:0]           req_kind;
        logic [ADDR_BITS-1:0] req_addr;
        logic [15:0]          req_data;
        logic                 busy;
    } t_res;

    function automatic logic [ADDR_BITS-1:0] add_inc(logic [ADDR_BITS-1:0] a,
                                                     logic [15:0] inc);
        logic [ADDR_BITS-1:0] s;
        s = ADDR_BITS'(signed'(inc));
        return a + s;
    endfunction

endpackage

// ===== sv/rob_front.sv =====
// ----------------------------------------------------------------------------
// rob_front
// Accepts beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module rob_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_reg_offset,
    input  logic [7:0]        i_write_byte,
    input  logic              i_word_access,
    input  logic [15:0]       i_mem_data,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output rob_pkg::t_item    o_q_item
);
    rob_pkg::t_item r_q [rob_pkg::QUEUE_DEPTH];
    logic           r_rd, n_rd;
    logic           r_wr, n_wr;
    logic [1:0]     r_cnt, n_cnt;
    rob_pkg::t_item w_item;
    logic           w_push;

    always_comb begin
        w_item.off   = i_reg_offset;
        w_item.wbyte = i_write_byte;
        w_item.word  = i_word_access;
        w_item.mem   = i_mem_data;
        case (i_kind)
            rob_pkg::KIND_WRITE: w_item.cls = (i_reg_offset >= rob_pkg::OFF_LIMIT) ?
                                              rob_pkg::CL_ERR : rob_pkg::CL_WRITE;
            rob_pkg::KIND_READ:  w_item.cls = (i_reg_offset >= rob_pkg::OFF_LIMIT) ?
                                              rob_pkg::CL_ERR : rob_pkg::CL_READ;
            rob_pkg::KIND_SLOT:  w_item.cls = rob_pkg::CL_SLOT;
            default:             w_item.cls = rob_pkg::CL_NONE;
        endcase
    end

    assign o_in_ready = (r_cnt != 2'(rob_pkg::QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt + 2'(w_push) - 2'(i_q_pop && o_q_valid);
        n_wr  = w_push ? ~r_wr : r_wr;
        n_rd  = (i_q_pop && o_q_valid) ? ~r_rd : r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_rd  <= n_rd;
            r_wr  <= n_wr;
        end
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(rob_pkg::QUEUE_DEPTH)) else $error("queue overfilled");
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_pop && o_q_valid && !w_push) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("pop count slip");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_rd == r_wr)) else $error("pointer slip");
endmodule

// ===== sv/rob_back.sv =====
// ----------------------------------------------------------------------------
// rob_back
// Executes one queued beat per cycle when not stalled: registers, bus slots, raster op.
// ----------------------------------------------------------------------------
module rob_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  rob_pkg::t_item i_q_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rob_pkg::t_res  o_res
);
    localparam int AB = rob_pkg::ADDR_BITS;

    logic [15:0]   r_ht [rob_pkg::HT_WORDS];
    logic [15:0]   n_ht [rob_pkg::HT_WORDS];
    logic [AB-1:0] r_src, n_src, r_dst, n_dst;
    logic [15:0]   r_inc [4];
    logic [15:0]   n_inc [4];
    logic [15:0]   r_em [3];
    logic [15:0]   n_em [3];
    logic [15:0]   r_wpl, n_wpl, r_lines, n_lines;
    logic [16:0]   r_wc, n_wc, r_lc, n_lc;
    logic [1:0]    r_hop, n_hop;
    logic [3:0]    r_op, n_op, r_skew, n_skew, r_li, n_li;
    logic          r_nfsr, n_nfsr, r_fxsr, n_fxsr, r_smudge, n_smudge, r_hog, n_hog;
    logic          r_busy, n_busy, r_last, n_last;
    logic [31:0]   r_sb, n_sb;
    logic [15:0]   r_mask, n_mask, r_hd, n_hd;
    rob_pkg::t_phase r_phase, n_phase;
    rob_pkg::t_res r_res, n_res;
    logic          r_ov;
    logic          w_go;

    assign o_q_pop     = i_q_valid && (!r_ov || i_out_ready);
    assign w_go        = o_q_pop;
    assign o_out_valid = r_ov;
    assign o_res       = r_res;

    always_comb begin
        logic        hi, bw, as, wr, rd, busy0, need;
        logic [7:0]  v, ve, o;
        logic [15:0] w, skewed, s, d, f, m, nd;
        n_ht = r_ht; n_src = r_src; n_dst = r_dst; n_inc = r_inc; n_em = r_em;
        n_wpl = r_wpl; n_lines = r_lines; n_wc = r_wc; n_lc = r_lc;
        n_hop = r_hop; n_op = r_op; n_skew = r_skew; n_li = r_li;
        n_nfsr = r_nfsr; n_fxsr = r_fxsr; n_smudge = r_smudge; n_hog = r_hog;
        n_busy = r_busy; n_last = r_last; n_sb = r_sb; n_mask = r_mask; n_hd = r_hd;
        n_phase = r_phase;
        n_res = '0;
        bw = 1'b0; as = 1'b0; wr = 1'b0; rd = 1'b0;
        o = i_q_item.off; v = i_q_item.wbyte;
        hi = ~o[0];
        ve = hi ? v : (v & 8'hFE);
        w = '0;
        skewed = '0; s = '0; d = '0; f = '0; m = '0; nd = '0; busy0 = 1'b0; need = 1'b0;
        case (i_q_item.cls)
            rob_pkg::CL_ERR: n_res.bus_error = 1'b1;
            rob_pkg::CL_READ: begin
                if (o < 8'h20) begin
                    w = r_ht[o[4:1]];
                    n_res.read_byte = o[0] ? w[7:0] : w[15:8];
                end else if (o >= 8'h25 && o <= 8'h27) begin
                    n_res.read_byte = 8'((r_src >> (8 * (8'h27 - o))) & AB'(8'hFF));
                end else if (o >= 8'h33 && o <= 8'h35) begin
                    n_res.read_byte = 8'((r_dst >> (8 * (8'h35 - o))) & AB'(8'hFF));
                end else if (o == 8'h24 || o == 8'h32) begin
                    n_res.read_byte = '0;
                end else begin
                    case ({o[7:1], 1'b0})
                        8'h20: w = r_inc[0];
                        8'h22: w = r_inc[1];
                        8'h28: w = r_em[0];
                        8'h2A: w = r_em[1];
                        8'h2C: w = r_em[2];
                        8'h2E: w = r_inc[2];
                        8'h30: w = r_inc[3];
                        8'h36: w = r_wpl;
                        8'h38: w = r_lines;
                        8'h3A: w = o[0] ? 16'({r_op}) : 16'({r_hop});
                        8'h3C: w = o[0] ? 16'({r_fxsr, r_nfsr, 2'b00, r_skew})
                                        : 16'({r_busy, r_hog, r_smudge, 1'b0, r_li});
                        default: w = '0;
                    endcase
                    if (o == 8'h3A || o == 8'h3B || o == 8'h3C || o == 8'h3D)
                        n_res.read_byte = w[7:0];
                    else
                        n_res.read_byte = o[0] ? w[7:0] : w[15:8];
                end
            end
            rob_pkg::CL_WRITE: begin
                if (o >= rob_pkg::OFF_BYTEOK || i_q_item.word) begin
                    if (o < 8'h20) begin
                        if (hi) n_ht[o[4:1]][15:8] = v; else n_ht[o[4:1]][7:0] = v;
                    end else if (o >= 8'h25 && o <= 8'h27) begin
                        case (o)
                            8'h25:   n_src = AB'({8'h0, v, r_src[15:0]}) | (r_src & ~AB'(24'hFF0000));
                            8'h26:   n_src = {r_src[AB-1:16], v, r_src[7:0]};
                            default: n_src = {r_src[AB-1:8], ve};
                        endcase
                    end else if (o >= 8'h33 && o <= 8'h35) begin
                        case (o)
                            8'h33:   n_dst = AB'({8'h0, v, r_dst[15:0]}) | (r_dst & ~AB'(24'hFF0000));
                            8'h34:   n_dst = {r_dst[AB-1:16], v, r_dst[7:0]};
                            default: n_dst = {r_dst[AB-1:8], ve};
                        endcase
                    end else begin
                        case ({o[7:1], 1'b0})
                            8'h20: if (hi) n_inc[0][15:8] = ve; else n_inc[0][7:0] = ve;
                            8'h22: if (hi) n_inc[1][15:8] = ve; else n_inc[1][7:0] = ve;
                            8'h28: if (hi) n_em[0][15:8] = v; else n_em[0][7:0] = v;
                            8'h2A: if (hi) n_em[1][15:8] = v; else n_em[1][7:0] = v;
                            8'h2C: if (hi) n_em[2][15:8] = v; else n_em[2][7:0] = v;
                            8'h2E: if (hi) n_inc[2][15:8] = ve; else n_inc[2][7:0] = ve;
                            8'h30: if (hi) n_inc[3][15:8] = ve; else n_inc[3][7:0] = ve;
                            8'h36: begin
                                if (hi) n_wpl[15:8] = v; else n_wpl[7:0] = v;
                                n_wc = (n_wpl != 16'd0) ? {1'b0, n_wpl} : 17'h10000;
                            end
                            8'h38: if (hi) n_lines[15:8] = v; else n_lines[7:0] = v;
                            8'h3A: begin
                                if (o[0]) n_op = v[3:0]; else n_hop = v[1:0];
                            end
                            8'h3C: begin
                                if (o[0]) begin
                                    n_skew = v[3:0]; n_nfsr = v[6]; n_fxsr = v[7];
                                end else begin
                                    n_li = v[3:0]; n_smudge = v[5]; n_hog = v[6];
                                    if (r_busy) begin
                                        if (!v[7]) begin
                                            n_busy = 1'b0;
                                            if (r_phase == rob_pkg::PH_RUN ||
                                                r_phase == rob_pkg::PH_PRE)
                                                n_phase = rob_pkg::PH_IDLE;
                                        end
                                    end else if (v[7] && r_lines != 16'd0) begin
                                        n_busy = 1'b1;
                                        n_lc = {1'b0, r_lines};
                                        if (r_phase == rob_pkg::PH_IDLE) begin
                                            if (r_wc[15:0] == r_wpl) begin
                                                n_mask = r_em[0]; n_last = 1'b0;
                                                n_phase = r_fxsr ? rob_pkg::PH_PRE
                                                                 : rob_pkg::PH_RUN;
                                            end else begin
                                                n_phase = rob_pkg::PH_RUN;
                                            end
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            rob_pkg::CL_SLOT: begin
                case (r_phase)
                    rob_pkg::PH_WPRE: begin
                        n_sb = r_inc[0][15] ? {i_q_item.mem, r_sb[31:16]}
                                            : {r_sb[15:0], i_q_item.mem};
                        n_phase = r_busy ? rob_pkg::PH_RUN : rob_pkg::PH_IDLE;
                        bw = r_busy;
                    end
                    rob_pkg::PH_WSRC: begin
                        n_sb = r_inc[0][15] ? {i_q_item.mem, r_sb[31:16]}
                                            : {r_sb[15:0], i_q_item.mem};
                        as = 1'b1;
                    end
                    rob_pkg::PH_WDST: begin
                        n_hd = i_q_item.mem;
                        wr = 1'b1;
                    end
                    rob_pkg::PH_PRE: begin
                        n_res.req_kind = rob_pkg::REQ_SRC;
                        n_res.req_addr = r_src;
                        n_src = rob_pkg::add_inc(r_src, r_inc[0]);
                        n_phase = rob_pkg::PH_WPRE;
                    end
                    rob_pkg::PH_RUN: bw = 1'b1;
                    default: ;
                endcase
                if (bw) begin
                    if (n_wc == 17'd1) begin
                        n_last = 1'b1;
                        if (r_wpl != 16'd1) n_mask = r_em[2];
                    end
                    if (r_op != 4'd0 && r_op != 4'd5 && r_op != 4'd10 && r_op != 4'd15 &&
                        r_hop[1]) begin
                        if (r_nfsr && n_last) begin
                            n_sb = r_inc[0][15] ? {16'h0, n_sb[31:16]} : {n_sb[15:0], 16'h0};
                        end else begin
                            n_res.req_kind = rob_pkg::REQ_SRC;
                            n_res.req_addr = n_src;
                            rd = 1'b1;
                        end
                        if (n_last) n_src = rob_pkg::add_inc(n_src, r_inc[1]);
                        else if (!(r_nfsr && n_wc == 17'd2))
                            n_src = rob_pkg::add_inc(n_src, r_inc[0]);
                    end
                    if (rd) n_phase = rob_pkg::PH_WSRC;
                    else as = 1'b1;
                end
                if (as) begin
                    need = r_op != 4'd0 && r_op != 4'd3 && r_op != 4'd12 && r_op != 4'd15;
                    if (need || n_mask != 16'hFFFF) begin
                        n_res.req_kind = rob_pkg::REQ_DST;
                        n_res.req_addr = n_dst;
                        n_phase = rob_pkg::PH_WDST;
                    end else begin
                        n_hd = '0;
                        wr = 1'b1;
                    end
                end
                if (wr) begin
                    skewed = 16'(n_sb >> r_skew);
                    case (r_hop)
                        2'd0: s = 16'hFFFF;
                        2'd1: s = r_smudge ? r_ht[skewed[3:0]] : r_ht[r_li];
                        2'd2: s = skewed;
                        default: s = skewed & (r_smudge ? r_ht[skewed[3:0]] : r_ht[r_li]);
                    endcase
                    d = n_hd; m = n_mask;
                    f = ({16{r_op[0]}} & s & d) | ({16{r_op[1]}} & s & ~d) |
                        ({16{r_op[2]}} & ~s & d) | ({16{r_op[3]}} & ~s & ~d);
                    nd = (d & ~m) | (f & m);
                    n_res.req_kind = rob_pkg::REQ_WRITE;
                    n_res.req_addr = n_dst;
                    n_res.req_data = nd;
                    n_dst = rob_pkg::add_inc(n_dst, n_last ? r_inc[3] : r_inc[2]);
                    n_mask = r_em[1];
                    busy0 = r_busy;
                    if (n_wc != 17'd0) n_wc = n_wc - 17'd1;
                    if (n_wc == 17'd0) begin
                        n_li = r_li + (r_inc[3][15] ? 4'd15 : 4'd1);
                        if (n_lc != 17'd0) n_lc = n_lc - 17'd1;
                        n_lines = n_lc[15:0];
                        n_wc = (r_wpl != 16'd0) ? {1'b0, r_wpl} : 17'h10000;
                        if (n_lc == 17'd0) begin
                            n_busy = 1'b0;
                            n_phase = rob_pkg::PH_IDLE;
                        end else begin
                            n_mask = r_em[0]; n_last = 1'b0;
                            n_phase = r_fxsr ? rob_pkg::PH_PRE : rob_pkg::PH_RUN;
                            if (!busy0) n_phase = rob_pkg::PH_IDLE;
                        end
                    end else begin
                        n_phase = busy0 ? rob_pkg::PH_RUN : rob_pkg::PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
        n_res.busy = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            for (int k = 0; k < rob_pkg::HT_WORDS; k++) r_ht[k] <= '0;
            for (int k = 0; k < 4; k++) r_inc[k] <= '0;
            for (int k = 0; k < 3; k++) r_em[k] <= '0;
            r_src <= '0; r_dst <= '0; r_wpl <= '0; r_lines <= '0;
            r_wc <= 17'h10000; r_lc <= '0;
            r_hop <= '0; r_op <= '0; r_skew <= '0; r_li <= '0;
            r_nfsr <= 1'b0; r_fxsr <= 1'b0; r_smudge <= 1'b0; r_hog <= 1'b0;
            r_busy <= 1'b0; r_last <= 1'b0;
            r_sb <= '0; r_mask <= '0; r_hd <= '0;
            r_phase <= rob_pkg::PH_IDLE;
        end else begin
            if (w_go) begin
                r_ov <= 1'b1;
                r_ht <= n_ht; r_inc <= n_inc; r_em <= n_em;
                r_src <= n_src; r_dst <= n_dst; r_wpl <= n_wpl; r_lines <= n_lines;
                r_wc <= n_wc; r_lc <= n_lc;
                r_hop <= n_hop; r_op <= n_op; r_skew <= n_skew; r_li <= n_li;
                r_nfsr <= n_nfsr; r_fxsr <= n_fxsr; r_smudge <= n_smudge; r_hog <= n_hog;
                r_busy <= n_busy; r_last <= n_last;
                r_sb <= n_sb; r_mask <= n_mask; r_hd <= n_hd;
                r_phase <= n_phase;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
        if (w_go) begin
            r_res <= n_res;
        end
    end

    a_wc_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc != 17'd0) else $error("word counter reached zero at rest");
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rob_pkg::PH_RUN || r_phase == rob_pkg::PH_PRE) |-> r_busy)
        else $error("running while not busy");
    a_none_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_res.req_kind == rob_pkg::REQ_NONE) |-> (r_res.req_addr == '0))
        else $error("address on empty request");
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_res.bus_error) |-> (r_res.req_kind == rob_pkg::REQ_NONE &&
                                        r_res.read_byte == 8'd0))
        else $error("bus error beat with payload");
endmodule

// ===== sv/raster_op_blitter.sv =====
// ----------------------------------------------------------------------------
// raster_op_blitter
// Bus-master blitter: queued beats, register window and raster op back end.
// ----------------------------------------------------------------------------
// An input beat passes the queue, then the result register, to its result beat.
// Throughput: 1 beat per cycle while i_out_ready takes each result beat; the
// back end retires one queued beat a cycle. A 2-entry queue decouples intake
// from the result register. Reset (i_rst_n low, synchronous) clears queue,
// registers and busy; the word counter resets to 65536.
module raster_op_blitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_reg_offset,
    input  logic [7:0]  i_write_byte,
    input  logic        i_word_access,
    input  logic [15:0] i_mem_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_byte,
    output logic        o_bus_error,
    output logic [1:0]  o_req_kind,
    output logic [23:0] o_req_addr,
    output logic [15:0] o_req_data,
    output logic        o_busy_res
);
    logic           w_q_valid, w_q_pop;
    rob_pkg::t_item w_q_item;
    rob_pkg::t_res  w_res;

    rob_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_kind(i_kind), .i_reg_offset(i_reg_offset), .i_write_byte(i_write_byte),
        .i_word_access(i_word_access), .i_mem_data(i_mem_data),
        .o_q_valid(w_q_valid), .i_q_pop(w_q_pop), .o_q_item(w_q_item)
    );

    rob_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_q_valid), .o_q_pop(w_q_pop), .i_q_item(w_q_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_res(w_res)
    );

    assign o_read_byte = w_res.read_byte;
    assign o_bus_error = w_res.bus_error;
    assign o_req_kind  = w_res.req_kind;
    assign o_req_addr  = w_res.req_addr;
    assign o_req_data  = w_res.req_data;
    assign o_busy_res  = w_res.busy;
endmodule

// ===== test/tb_raster_op_blitter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_raster_op_blitter
// Drives register writes, register reads and bus slots through the blitter,
// predicts each result beat with an independent model of the blit engine and
// compares every field. Covers directed register and blit cases, then random
// blit programs with memory answers, under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_raster_op_blitter;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  off;
        logic [7:0]  wbyte;
        logic        word;
        logic [15:0] mem;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_kind;
    logic [7:0]  i_reg_offset;
    logic [7:0]  i_write_byte;
    logic        i_word_access;
    logic [15:0] i_mem_data;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_read_byte;
    logic        o_bus_error;
    logic [1:0]  o_req_kind;
    logic [23:0] o_req_addr;
    logic [15:0] o_req_data;
    logic        o_busy_res;

    raster_op_blitter i_dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // blit engine state
    logic [15:0] ht_ram [rob_pkg::HT_WORDS];
    logic [23:0] src_addr, dst_addr;
    logic [15:0] incs [4];
    logic [15:0] emask [3];
    logic [15:0] xcount, ycount;
    logic [16:0] word_cnt, line_cnt;
    logic [1:0]  hop;
    logic [3:0]  op, skew, line_num;
    logic        nfsr, fxsr, smudge, hog, busy, last_word;
    logic [31:0] shift_buf;
    logic [15:0] cur_mask, dst_word;
    rob_pkg::t_phase ph;
    rob_pkg::t_res   pend;

    t_beat         beat_q [$];
    rob_pkg::t_res result_q [$];
    int    errors, phase_sel, hold_cnt, stall_left, accepted, results_seen;
    logic  drain_req;

    function automatic logic [23:0] step_addr(logic [23:0] a, logic [15:0] inc);
        return a + {{8{inc[15]}}, inc};
    endfunction

    function automatic void issue_req(logic [1:0] k, logic [23:0] a, logic [15:0] d);
        pend.req_kind = k;
        pend.req_addr = a;
        pend.req_data = d;
    endfunction

    function automatic void load_shift(logic [15:0] d);
        if (incs[0][15]) shift_buf = {d, shift_buf[31:16]};
        else shift_buf = {shift_buf[15:0], d};
    endfunction

    function automatic void start_line();
        cur_mask = emask[0];
        last_word = 1'b0;
        ph = fxsr ? rob_pkg::PH_PRE : rob_pkg::PH_RUN;
    endfunction

    function automatic void write_word();
        logic [15:0] skewed, s, d, f, nd;
        logic        was_busy;
        skewed = 16'(shift_buf >> skew);
        d = dst_word;
        f = '0;
        if (hop == 2'd0) s = 16'hFFFF;
        else if (hop == 2'd1) s = smudge ? ht_ram[skewed[3:0]] : ht_ram[line_num];
        else begin
            s = skewed;
            if (hop == 2'd3) s = s & (smudge ? ht_ram[s[3:0]] : ht_ram[line_num]);
        end
        if (op[0]) f |= s & d;
        if (op[1]) f |= s & ~d;
        if (op[2]) f |= ~s & d;
        if (op[3]) f |= ~s & ~d;
        nd = (d & ~cur_mask) | (f & cur_mask);
        issue_req(rob_pkg::REQ_WRITE, dst_addr, nd);
        dst_addr = step_addr(dst_addr, last_word ? incs[3] : incs[2]);
        cur_mask = emask[1];
        was_busy = busy;
        if (word_cnt > 0) word_cnt--;
        if (word_cnt == 0) begin
            line_num = line_num + (incs[3][15] ? 4'd15 : 4'd1);
            if (line_cnt > 0) line_cnt--;
            ycount = line_cnt[15:0];
            word_cnt = (xcount != 0) ? {1'b0, xcount} : 17'h10000;
            if (line_cnt == 0) begin
                busy = 1'b0;
                ph = rob_pkg::PH_IDLE;
            end else begin
                start_line();
                if (!was_busy) ph = rob_pkg::PH_IDLE;
            end
        end else begin
            ph = was_busy ? rob_pkg::PH_RUN : rob_pkg::PH_IDLE;
        end
    endfunction

    function automatic void source_done();
        logic need_dst;
        need_dst = !(op inside {4'd0, 4'd3, 4'd12, 4'd15});
        if (need_dst || cur_mask != 16'hFFFF) begin
            issue_req(rob_pkg::REQ_DST, dst_addr, '0);
            ph = rob_pkg::PH_WDST;
        end else begin
            dst_word = '0;
            write_word();
        end
    endfunction

    function automatic void start_word();
        logic rd;
        rd = 1'b0;
        if (word_cnt == 1) begin
            last_word = 1'b1;
            if (xcount != 1) cur_mask = emask[2];
        end
        if ((op % 5) != 0 && hop > 2'd1) begin
            if (nfsr && last_word) begin
                if (incs[0][15]) shift_buf = shift_buf >> 16;
                else shift_buf = shift_buf << 16;
            end else begin
                issue_req(rob_pkg::REQ_SRC, src_addr, '0);
                rd = 1'b1;
            end
            if (last_word) src_addr = step_addr(src_addr, incs[1]);
            else if (!(nfsr && word_cnt == 2)) src_addr = step_addr(src_addr, incs[0]);
        end
        if (rd) ph = rob_pkg::PH_WSRC;
        else source_done();
    endfunction

    function automatic void bus_cycle(logic [15:0] d);
        if (ph == rob_pkg::PH_WPRE) begin
            load_shift(d);
            ph = busy ? rob_pkg::PH_RUN : rob_pkg::PH_IDLE;
        end else if (ph == rob_pkg::PH_WSRC) begin
            load_shift(d);
            source_done();
            return;
        end else if (ph == rob_pkg::PH_WDST) begin
            dst_word = d;
            write_word();
            return;
        end
        if (ph == rob_pkg::PH_PRE) begin
            issue_req(rob_pkg::REQ_SRC, src_addr, '0);
            src_addr = step_addr(src_addr, incs[0]);
            ph = rob_pkg::PH_WPRE;
        end else if (ph == rob_pkg::PH_RUN) begin
            start_word();
        end
    endfunction

    function automatic logic [7:0] sel_byte(logic [15:0] w, logic [7:0] o);
        return o[0] ? w[7:0] : w[15:8];
    endfunction

    function automatic logic [7:0] read_reg(logic [7:0] o);
        if (o < 8'h20) return sel_byte(ht_ram[o[4:1]], o);
        if (o >= 8'h24 && o <= 8'h27)
            return (o == 8'h24) ? 8'h0 : 8'(src_addr >> (8 * (8'h27 - o)));
        if (o >= 8'h32 && o <= 8'h35)
            return (o == 8'h32) ? 8'h0 : 8'(dst_addr >> (8 * (8'h35 - o)));
        case ({o[7:1], 1'b0})
            8'h20: return sel_byte(incs[0], o);
            8'h22: return sel_byte(incs[1], o);
            8'h28: return sel_byte(emask[0], o);
            8'h2A: return sel_byte(emask[1], o);
            8'h2C: return sel_byte(emask[2], o);
            8'h2E: return sel_byte(incs[2], o);
            8'h30: return sel_byte(incs[3], o);
            8'h36: return sel_byte(xcount, o);
            8'h38: return sel_byte(ycount, o);
            8'h3A: return o[0] ? {4'h0, op} : {6'h0, hop};
            8'h3C: return o[0] ? {fxsr, nfsr, 2'b0, skew}
                              : {busy, hog, smudge, 1'b0, line_num};
            default: return 8'h0;
        endcase
    endfunction

    function automatic void put_half(ref logic [15:0] w, input logic hi, input logic [7:0] v);
        if (hi) w[15:8] = v;
        else w[7:0] = v;
    endfunction

    function automatic void write_reg(logic [7:0] o, logic [7:0] v, logic wd);
        logic       hi;
        logic [7:0] ve;
        hi = !o[0];
        ve = hi ? v : (v & 8'hFE);
        if (o < rob_pkg::OFF_BYTEOK && !wd) return;
        if (o < 8'h20) begin
            put_half(ht_ram[o[4:1]], hi, v);
            return;
        end
        if (o >= 8'h25 && o <= 8'h27) begin
            case (o)
                8'h25: src_addr[23:16] = v;
                8'h26: src_addr[15:8] = v;
                default: src_addr[7:0] = ve;
            endcase
            return;
        end
        if (o >= 8'h33 && o <= 8'h35) begin
            case (o)
                8'h33: dst_addr[23:16] = v;
                8'h34: dst_addr[15:8] = v;
                default: dst_addr[7:0] = ve;
            endcase
            return;
        end
        case ({o[7:1], 1'b0})
            8'h20: begin put_half(incs[0], hi, ve); return; end
            8'h22: begin put_half(incs[1], hi, ve); return; end
            8'h28: begin put_half(emask[0], hi, v); return; end
            8'h2A: begin put_half(emask[1], hi, v); return; end
            8'h2C: begin put_half(emask[2], hi, v); return; end
            8'h2E: begin put_half(incs[2], hi, ve); return; end
            8'h30: begin put_half(incs[3], hi, ve); return; end
            8'h36: begin
                put_half(xcount, hi, v);
                word_cnt = (xcount != 0) ? {1'b0, xcount} : 17'h10000;
                return;
            end
            8'h38: begin put_half(ycount, hi, v); return; end
            default: ;
        endcase
        if (o == 8'h3A) hop = v[1:0];
        else if (o == 8'h3B) op = v[3:0];
        else if (o == 8'h3D) begin
            skew = v[3:0];
            nfsr = v[6];
            fxsr = v[7];
        end else if (o == 8'h3C) begin
            line_num = v[3:0];
            smudge = v[5];
            hog = v[6];
            if (busy) begin
                if (!v[7]) begin
                    busy = 1'b0;
                    if (ph == rob_pkg::PH_RUN || ph == rob_pkg::PH_PRE) ph = rob_pkg::PH_IDLE;
                end
            end else if (v[7] && ycount != 0) begin
                busy = 1'b1;
                line_cnt = {1'b0, ycount};
                if (ph == rob_pkg::PH_IDLE) begin
                    if (16'(word_cnt - {1'b0, xcount}) == 0) start_line();
                    else ph = rob_pkg::PH_RUN;
                end
            end
        end
    endfunction

    function automatic rob_pkg::t_res predict_blit(t_beat b);
        pend = '0;
        if (b.kind == rob_pkg::KIND_WRITE || b.kind == rob_pkg::KIND_READ) begin
            if (b.off >= rob_pkg::OFF_LIMIT) pend.bus_error = 1'b1;
            else if (b.kind == rob_pkg::KIND_WRITE) write_reg(b.off, b.wbyte, b.word);
            else pend.read_byte = read_reg(b.off);
        end else if (b.kind == rob_pkg::KIND_SLOT) begin
            bus_cycle(b.mem);
        end
        pend.busy = busy;
        return pend;
    endfunction

    function automatic void reset_blit();
        foreach (ht_ram[i]) ht_ram[i] = '0;
        foreach (incs[i]) incs[i] = '0;
        foreach (emask[i]) emask[i] = '0;
        src_addr = '0; dst_addr = '0; xcount = '0; ycount = '0;
        word_cnt = 17'h10000; line_cnt = '0;
        hop = '0; op = '0; skew = '0; line_num = '0;
        nfsr = 0; fxsr = 0; smudge = 0; hog = 0; busy = 0; last_word = 0;
        shift_buf = '0; cur_mask = '0; dst_word = '0; ph = rob_pkg::PH_IDLE;
    endfunction

    // stimulus helpers
    task automatic push(logic [1:0] k, logic [7:0] o, logic [7:0] v, logic w,
                        logic [15:0] m);
        beat_q.push_back('{k, o, v, w, m});
    endtask

    task automatic push_word(logic [7:0] o, logic [15:0] v);
        push(rob_pkg::KIND_WRITE, o, v[15:8], 1'b1, 16'(4'hF));
        push(rob_pkg::KIND_WRITE, o | 8'h1, v[7:0], 1'b1, 16'($urandom));
    endtask

    task automatic push_slots(int n);
        repeat (n) push(rob_pkg::KIND_SLOT, 8'($urandom), 8'($urandom), 1'($urandom),
                        16'($urandom));
    endtask

    task automatic push_blit(int xc, int yc);
        int r;
        r = $urandom_range(0, 3);
        for (int i = 0; i < 16; i++)
            if ($urandom_range(0, 3) == 0) push_word(8'(2 * i), 16'($urandom));
        push_word(8'h20, (r == 0) ? 16'hFFFE : 16'($urandom_range(0, 8) * 2));
        push_word(8'h22, 16'($urandom));
        push_word(8'h24, 16'($urandom));
        push_word(8'h26, 16'($urandom));
        push_word(8'h28, ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom));
        push_word(8'h2A, ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom));
        push_word(8'h2C, 16'($urandom));
        push_word(8'h2E, 16'($urandom));
        push_word(8'h30, (r == 1) ? 16'hFFFE : 16'($urandom));
        push_word(8'h32, 16'($urandom));
        push_word(8'h34, 16'($urandom));
        push_word(8'h36, 16'(xc));
        push_word(8'h38, 16'(yc));
        push(rob_pkg::KIND_WRITE, 8'h3A, 8'($urandom), 1'($urandom), 16'($urandom));
        push(rob_pkg::KIND_WRITE, 8'h3B, 8'($urandom), 1'($urandom), 16'($urandom));
        push(rob_pkg::KIND_WRITE, 8'h3D, 8'($urandom), 1'($urandom), 16'($urandom));
        push(rob_pkg::KIND_WRITE, 8'h3C, {1'b1, 7'($urandom)}, 1'($urandom),
             16'($urandom));
        push_slots(xc * yc * 3 + 4);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (beat_q.size() != 0 && !drain_req && hold_cnt == 0 &&
                !((phase_sel == 1 || phase_sel == 3) &&
                  $urandom_range(0, 99) < (phase_sel == 1 ? 57 : 31))) begin
                t_beat b;
                b = beat_q.pop_front();
                i_in_valid <= 1'b1;
                i_kind <= b.kind;
                i_reg_offset <= b.off;
                i_write_byte <= b.wbyte;
                i_word_access <= b.word;
                i_mem_data <= b.mem;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            result_q.push_back(predict_blit('{i_kind, i_reg_offset, i_write_byte,
                                              i_word_access, i_mem_data}));
            accepted <= accepted + 1;
        end
    end

    // receiver with stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !((phase_sel == 2 || phase_sel == 3) &&
                             $urandom_range(0, 99) < (phase_sel == 2 ? 57 : 31));
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (result_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                rob_pkg::t_res e;
                e = result_q.pop_front();
                if (o_read_byte !== e.read_byte) begin
                    $error("read_byte exp %h got %h", e.read_byte, o_read_byte);
                    errors++;
                end
                if (o_bus_error !== e.bus_error) begin
                    $error("bus_error exp %h got %h", e.bus_error, o_bus_error);
                    errors++;
                end
                if (o_req_kind !== e.req_kind) begin
                    $error("req_kind exp %h got %h", e.req_kind, o_req_kind);
                    errors++;
                end
                if (o_req_addr !== e.req_addr) begin
                    $error("req_addr exp %h got %h", e.req_addr, o_req_addr);
                    errors++;
                end
                if (o_req_data !== e.req_data) begin
                    $error("req_data exp %h got %h", e.req_data, o_req_data);
                    errors++;
                end
                if (o_busy_res !== e.busy) begin
                    $error("busy_res exp %h got %h", e.busy, o_busy_res);
                    errors++;
                end
            end
        end
    end

    // watchdog
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0; i_kind = '0; i_reg_offset = '0; i_write_byte = '0;
        i_word_access = 1'b0; i_mem_data = '0; i_out_ready = 1'b0;
        errors = 0; phase_sel = 0; hold_cnt = 0; stall_left = 0;
        accepted = 0; results_seen = 0; drain_req = 1'b0; idle_cycles = 0;
        reset_blit();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: errors, ignored byte writes, reads, extremes, blit cases
        push(rob_pkg::KIND_WRITE, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);
        push(rob_pkg::KIND_READ, 8'h40, 8'h00, 1'b0, 16'h0000);
        push(rob_pkg::KIND_WRITE, 8'h00, 8'hFF, 1'b0, 16'h0000);
        push_word(8'h00, 16'hFFFF);
        push_word(8'h24, 16'h00FF);
        push_word(8'h26, 16'hFFFF);
        push(rob_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 16'h0000);
        push(rob_pkg::KIND_READ, 8'h27, 8'h00, 1'b0, 16'h0000);
        push(rob_pkg::KIND_READ, 8'h24, 8'h00, 1'b0, 16'h0000);
        push(rob_pkg::KIND_READ, 8'h3F, 8'h00, 1'b0, 16'h0000);
        push(rob_pkg::KIND_WRITE, 8'h3C, 8'h80, 1'b0, 16'h0000);
        push(rob_pkg::KIND_NONE, 8'h00, 8'h00, 1'b0, 16'h0000);
        push_slots(2);
        push_blit(1, 1);
        push_blit(3, 2);
        for (int n = 0; n < 4; n++) begin
            push_blit($urandom_range(1, 4), $urandom_range(1, 3));
            push(rob_pkg::KIND_WRITE, 8'h3C, 8'h00, 1'b0, 16'h0);
            push_slots(2);
            push(rob_pkg::KIND_WRITE, 8'h3C, 8'h80, 1'b0, 16'h0);
            push_slots(8);
        end

        for (int p = 0; p < 5; p++) begin
            wait (beat_q.size() == 0 && result_q.size() == 0);
            repeat (4) @(posedge i_clk);
            phase_sel = (p == 4) ? 0 : p;
            if (p == 2) stall_left = 300;
            if (p == 3) begin
                drain_req = 1'b1;
                wait (result_q.size() == 0);
                drain_req = 1'b0;
            end
            while (beat_q.size() < 180) begin
                case ($urandom_range(0, 9))
                    0: push(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                            1'($urandom), 16'($urandom));
                    1: push(rob_pkg::KIND_READ, 8'($urandom_range(0, 63)), 8'd0, 1'b0,
                            16'($urandom));
                    2: push(rob_pkg::KIND_WRITE, 8'h3C, 8'($urandom), 1'b0, 16'd0);
                    default: push_blit($urandom_range(1, 3), $urandom_range(1, 3));
                endcase
            end
        end

        wait (beat_q.size() == 0 && result_q.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("Checked %0d beats, %0d result beats: register access, blits, stalls.",
                 accepted, results_seen);
        if (errors == 0 && result_q.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== raster_op_blitter.f =====
sv/rob_pkg.sv
sv/rob_front.sv
sv/rob_back.sv
sv/raster_op_blitter.sv
test/tb_raster_op_blitter.sv
